### src/mvr_pkg.sv
// shared types, codes and constants for the motor velocity ramp and pid block
// no dependencies
package mvr_pkg;

  localparam int STALL_LIMIT_DEF = 100;
  localparam int ADDR_W = 4;

  localparam logic [2:0] OP_RAMP    = 3'd0;
  localparam logic [2:0] OP_CONTROL = 3'd1;
  localparam logic [2:0] OP_TARGET  = 3'd2;
  localparam logic [2:0] OP_OPEN    = 3'd3;
  localparam logic [2:0] OP_LOCK    = 3'd4;

  localparam logic [1:0] REG_ACCEL  = 2'd0;
  localparam logic [1:0] REG_GAIN_P = 2'd1;
  localparam logic [1:0] REG_GAIN_I = 2'd2;
  localparam logic [1:0] REG_GAIN_D = 2'd3;

  localparam logic [9:0] ACCEL_MIN   = 10'd2;
  localparam logic [9:0] ACCEL_MAX   = 10'd1000;
  localparam logic [9:0] ACCEL_RESET = 10'd100;

  // drive scale and its reciprocal: floor(n / 10000) = (n * DIV_MAGIC) >> DIV_SHIFT
  localparam int          PWM_SCALE = 10000;
  localparam logic [31:0] DIV_MAGIC = 32'd3518437209;
  localparam int          DIV_SHIFT = 45;

  typedef struct packed {
    logic [9:0]  accel;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] meas;
    logic [15:0] tgt;
    logic [18:0] pwm;
  } item_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [16:0] ramp;
    logic [16:0] goal;
    logic        good;
    logic        closed;
  } status_t;

endpackage

### src/mvr_cfg.sv
// configuration registers behind the apb-style port: acceleration and pid gains
// depends on mvr_pkg
module mvr_cfg import mvr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [9:0] accel_wr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    accel_wr = pwdata[9:0];
    if (accel_wr < ACCEL_MIN) begin
      accel_wr = ACCEL_MIN;
    end else if (accel_wr > ACCEL_MAX) begin
      accel_wr = ACCEL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel  <= ACCEL_RESET;
      cfg.gain_p <= '0;
      cfg.gain_i <= '0;
      cfg.gain_d <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ACCEL:  cfg.accel  <= accel_wr;
        REG_GAIN_P: cfg.gain_p <= pwdata[15:0];
        REG_GAIN_I: cfg.gain_i <= pwdata[15:0];
        REG_GAIN_D: cfg.gain_d <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ACCEL:  prdata = {22'd0, cfg.accel};
      REG_GAIN_P: prdata = {{16{cfg.gain_p[15]}}, cfg.gain_p};
      REG_GAIN_I: prdata = {{16{cfg.gain_i[15]}}, cfg.gain_i};
      REG_GAIN_D: prdata = {{16{cfg.gain_d[15]}}, cfg.gain_d};
      default:    prdata = '0;
    endcase
  end

endmodule

### src/mvr_core.sv
// controller state and its combinational update: ramp, incremental pid, stall watch
// depends on mvr_pkg
module mvr_core import mvr_pkg::*; #(
  parameter int STALL_LIMIT = STALL_LIMIT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output status_t status
);

  logic signed [16:0] ramp_velocity, ramp_velocity_next;
  logic signed [16:0] goal_velocity, goal_velocity_next;
  logic signed [11:0] ramp_remainder, ramp_remainder_next;
  logic signed [31:0] drive_accumulator, drive_accumulator_next;
  logic               closed_flag, closed_flag_next;
  logic               encoder_good, encoder_good_next;
  logic [7:0]         stall_count, stall_count_next;
  logic signed [17:0] error_last, error_last_next;
  logic signed [17:0] error_before_last, error_before_last_next;

  logic signed [17:0] meas_x;
  logic signed [17:0] ramp_x;
  logic signed [17:0] diff;
  logic [17:0]        mag_diff;
  logic               accel_full;
  logic               moving;
  logic signed [11:0] accel_s;
  logic signed [11:0] rem_step;
  logic signed [11:0] rem_sum;
  logic signed [11:0] rem_carried;
  logic signed [16:0] ramp_delta;
  logic signed [16:0] ramp_ramped;

  logic signed [17:0] err;
  logic signed [18:0] d1;
  logic signed [19:0] d2;
  logic signed [34:0] p_term;
  logic signed [33:0] i_term;
  logic signed [35:0] d_term;
  logic signed [36:0] pid;
  logic signed [37:0] acc_sum;
  logic signed [33:0] open_prod;
  logic [7:0]         count_inc;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // ramp step toward the goal with fractional carry
  always_comb begin
    meas_x      = 18'($signed(item.meas));
    ramp_x      = 18'(ramp_velocity);
    diff        = 18'(goal_velocity) - ramp_x;
    mag_diff    = diff[17] ? 18'(-diff) : 18'(diff);
    accel_full  = (cfg.accel == ACCEL_MAX);
    moving      = (mag_diff > 18'd1) || ((mag_diff == 18'd1) && !accel_full);
    accel_s     = $signed({2'b00, cfg.accel});
    rem_step    = accel_full ? 12'sd0 : (diff[17] ? -accel_s : accel_s);
    rem_sum     = ramp_remainder + rem_step;
    ramp_delta  = accel_full ? (diff[17] ? -17'sd1 : 17'sd1) : 17'sd0;
    rem_carried = rem_sum;
    if (rem_sum > 12'sd1000) begin
      rem_carried = rem_sum - 12'sd1000;
      ramp_delta  = ramp_delta + 17'sd1;
    end else if (rem_sum < -12'sd1000) begin
      rem_carried = rem_sum + 12'sd1000;
      ramp_delta  = ramp_delta - 17'sd1;
    end
    ramp_ramped = ramp_velocity + ramp_delta;
  end

  // incremental pid term and open-loop drive
  always_comb begin
    err       = ramp_x - meas_x;
    d1        = 19'(err) - 19'(error_last);
    d2        = 20'(err) + 20'(error_before_last) - (20'(error_last) <<< 1);
    p_term    = $signed(cfg.gain_p) * d1;
    i_term    = $signed(cfg.gain_i) * err;
    d_term    = $signed(cfg.gain_d) * d2;
    pid       = 37'(p_term) + 37'(i_term) + 37'(d_term);
    acc_sum   = 38'(drive_accumulator) + 38'(pid);
    open_prod = 34'($signed(item.pwm)) * 34'sd10000;
    count_inc = (stall_count == 8'hff) ? stall_count : stall_count + 8'd1;
  end

  always_comb begin
    ramp_velocity_next     = ramp_velocity;
    goal_velocity_next     = goal_velocity;
    ramp_remainder_next    = ramp_remainder;
    drive_accumulator_next = drive_accumulator;
    closed_flag_next       = closed_flag;
    encoder_good_next      = encoder_good;
    stall_count_next       = stall_count;
    error_last_next        = error_last;
    error_before_last_next = error_before_last;
    case (item.opcode)
      OP_RAMP: begin
        if (moving) begin
          ramp_velocity_next  = ramp_ramped;
          ramp_remainder_next = rem_carried;
        end else begin
          ramp_velocity_next  = goal_velocity;
          ramp_remainder_next = '0;
        end
      end
      OP_CONTROL: begin
        if (closed_flag && encoder_good) begin
          if ((ramp_velocity != 17'sd0) && (item.meas == 16'd0)) begin
            stall_count_next = count_inc;
            if (count_inc > 8'(STALL_LIMIT)) begin
              encoder_good_next = 1'b0;
            end
          end else begin
            stall_count_next = '0;
          end
          drive_accumulator_next = sat32(acc_sum);
        end else begin
          if (closed_flag && !encoder_good) begin
            drive_accumulator_next = '0;
          end
          if (encoder_good) begin
            goal_velocity_next = 17'($signed(item.meas));
            ramp_velocity_next = 17'($signed(item.meas));
          end
          if (!encoder_good && (item.meas != 16'd0)) begin
            stall_count_next  = '0;
            encoder_good_next = 1'b1;
          end
        end
        error_before_last_next = error_last;
        error_last_next        = (encoder_good && !closed_flag) ? 18'sd0 : err;
      end
      OP_TARGET: begin
        goal_velocity_next = 17'($signed(item.tgt));
        closed_flag_next   = 1'b1;
      end
      OP_OPEN: begin
        drive_accumulator_next = sat32(38'(open_prod));
        closed_flag_next       = 1'b0;
      end
      OP_LOCK: begin
        ramp_velocity_next = '0;
        goal_velocity_next = '0;
        closed_flag_next   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_velocity     <= '0;
      goal_velocity     <= '0;
      ramp_remainder    <= '0;
      drive_accumulator <= '0;
      closed_flag       <= 1'b0;
      encoder_good      <= 1'b1;
      stall_count       <= '0;
      error_last        <= '0;
      error_before_last <= '0;
    end else if (fire) begin
      ramp_velocity     <= ramp_velocity_next;
      goal_velocity     <= goal_velocity_next;
      ramp_remainder    <= ramp_remainder_next;
      drive_accumulator <= drive_accumulator_next;
      closed_flag       <= closed_flag_next;
      encoder_good      <= encoder_good_next;
      stall_count       <= stall_count_next;
      error_last        <= error_last_next;
      error_before_last <= error_before_last_next;
    end
  end

  assign status.acc    = drive_accumulator_next;
  assign status.ramp   = ramp_velocity_next;
  assign status.goal   = goal_velocity_next;
  assign status.good   = encoder_good_next;
  assign status.closed = closed_flag_next;

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (ramp_remainder >= -12'sd1000) && (ramp_remainder <= 12'sd1000))
    else $error("ramp remainder out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(fire)) |->
      ($stable(drive_accumulator) && $stable(ramp_velocity) && $stable(encoder_good)))
    else $error("state changed without a transaction");

  a_ramp_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(fire) && ($past(item.opcode) == OP_RAMP)) |->
      ((ramp_velocity == goal_velocity) ||
       (ramp_velocity == $past(ramp_velocity)) ||
       (ramp_velocity == $past(ramp_velocity) + 17'sd1) ||
       (ramp_velocity == $past(ramp_velocity) - 17'sd1)))
    else $error("ramp moved more than one unit");

  a_enc_fall: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(encoder_good)) |->
      $past(fire && (item.opcode == OP_CONTROL) && closed_flag))
    else $error("encoder dropped outside a closed-loop control tick");

endmodule

### src/motor_velocity_ramp_pid.sv
// top level of the motor velocity ramp and incremental pid drive
// depends on mvr_pkg, mvr_cfg and mvr_core
//
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   opcode, measured_velocity,
//                                                target_velocity, open_loop_pwm
// result    out        result_valid / result_stall  pwm_drive, commanded_velocity,
//                                                target_now, encoder_ok, loop_closed
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// one transaction per cycle sustained while result_stall is low; a taken
// transaction waits in the input register; the state update, including the pid
// multiply and accumulate, runs from it into the result register and sets
// result_valid; the result register frees each cycle its transaction is taken,
// so a stall on the result side reaches item_stall only while both registers
// are full; reset is synchronous and clears the state and both valid flags
module motor_velocity_ramp_pid import mvr_pkg::*; #(
  parameter int STALL_LIMIT = STALL_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [2:0]        opcode,
  input  logic [15:0]       measured_velocity,
  input  logic [15:0]       target_velocity,
  input  logic [18:0]       open_loop_pwm,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [18:0]       pwm_drive,
  output logic [15:0]       commanded_velocity,
  output logic [15:0]       target_now,
  output logic              encoder_ok,
  output logic              loop_closed
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_v;
  status_t status;
  status_t res_q;
  logic    fire;
  logic    take;

  logic        acc_neg;
  logic [31:0] acc_mag;
  logic [63:0] quot_prod;
  logic [18:0] quot;

  mvr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mvr_core #(
    .STALL_LIMIT (STALL_LIMIT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item_q),
    .cfg    (cfg),
    .status (status)
  );

  assign fire       = item_v && (!result_valid || !result_stall);
  assign item_stall = item_v && !fire;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (take) begin
      item_v <= 1'b1;
    end else if (fire) begin
      item_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_q.opcode <= opcode;
      item_q.meas   <= measured_velocity;
      item_q.tgt    <= target_velocity;
      item_q.pwm    <= open_loop_pwm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= status;
    end
  end

  // drive / 10000 truncated toward zero, by reciprocal multiply on the magnitude
  always_comb begin
    acc_neg   = res_q.acc[31];
    acc_mag   = acc_neg ? 32'(-res_q.acc) : res_q.acc;
    quot_prod = 64'(acc_mag) * 64'(DIV_MAGIC);
    quot      = quot_prod[DIV_SHIFT +: 19];
  end

  assign pwm_drive          = acc_neg ? 19'(-quot) : quot;
  assign commanded_velocity = res_q.ramp[15:0];
  assign target_now         = res_q.goal[15:0];
  assign encoder_ok         = res_q.good;
  assign loop_closed        = res_q.closed;

endmodule

### tb/tb_motor_velocity_ramp_pid.sv
// self-checking testbench for motor_velocity_ramp_pid: ramp, pid, stall and open-loop paths
// depends on mvr_pkg and the rtl under src; a built-in drive model predicts every result
`timescale 1ns / 1ps

module tb_motor_velocity_ramp_pid;
  import mvr_pkg::*;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int         NUM_PHASES = 6;
  localparam int         PHASE_ITEMS = 230;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         REPORT_CAP = 100;

  typedef struct {
    int pwm;
    int cmd;
    int tgt;
    int ok;
    int closed;
  } drive_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [2:0]        opcode = '0;
  logic [15:0]       measured_velocity = '0;
  logic [15:0]       target_velocity = '0;
  logic [18:0]       open_loop_pwm = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [18:0]       pwm_drive;
  logic [15:0]       commanded_velocity;
  logic [15:0]       target_now;
  logic              encoder_ok;
  logic              loop_closed;

  motor_velocity_ramp_pid u_top (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .item_valid         (item_valid),
    .item_stall         (item_stall),
    .opcode             (opcode),
    .measured_velocity  (measured_velocity),
    .target_velocity    (target_velocity),
    .open_loop_pwm      (open_loop_pwm),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .pwm_drive          (pwm_drive),
    .commanded_velocity (commanded_velocity),
    .target_now         (target_now),
    .encoder_ok         (encoder_ok),
    .loop_closed        (loop_closed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // drive model state
  logic        [9:0]  accel_q = ACCEL_RESET;
  logic signed [15:0] kp_q = '0;
  logic signed [15:0] ki_q = '0;
  logic signed [15:0] kd_q = '0;
  logic signed [16:0] ramp_q = '0;
  logic signed [16:0] goal_q = '0;
  logic signed [11:0] rem_q = '0;
  logic signed [31:0] acc_q = '0;
  logic               closed_q = 1'b0;
  logic               good_q = 1'b1;
  logic        [7:0]  stall_q = '0;
  logic signed [17:0] err1_q = '0;
  logic signed [17:0] err2_q = '0;

  item_t         pending_items[$];
  drive_result_t drive_reports_due[$];

  int mismatches = 0;
  int items_taken = 0;
  int results_checked = 0;
  int encoder_drops = 0;
  int encoder_recoveries = 0;
  int settings_applied = 0;
  int phase_items = 0;
  int cycles = 0;
  int send_odds = 6;
  int recv_odds = 6;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic advance_drive_model(input logic [2:0] op, input logic [15:0] meas_in,
                                     input logic [15:0] tgt_in, input logic [18:0] pwm_in);
    longint r, g, rem, acc, m, t, p, a, diff, step, carry, err, e1, e2, pid;
    drive_result_t rep;
    r = ramp_q;
    g = goal_q;
    rem = rem_q;
    acc = acc_q;
    m = $signed(meas_in);
    t = $signed(tgt_in);
    p = $signed(pwm_in);
    a = accel_q;
    e1 = err1_q;
    e2 = err2_q;
    case (op)
      OP_RAMP: begin
        diff = g - r;
        if (mag(diff) * 1000 > a) begin
          step = (diff > 0) ? a : -a;
          r = r + step / 1000;
          rem = rem + step % 1000;
          if (mag(rem) > 1000) begin
            carry = rem / 1000;
            rem = rem - carry * 1000;
            r = r + carry;
          end
        end else begin
          r = g;
          rem = 0;
        end
      end
      OP_CONTROL: begin
        err = r - m;
        pid = longint'(kp_q) * (err - e1) + longint'(ki_q) * err
            + longint'(kd_q) * (err + e2 - 2 * e1);
        if (closed_q && good_q) begin
          if (r != 0 && m == 0) begin
            if (stall_q < 8'd255) stall_q = stall_q + 8'd1;
            if (stall_q > STALL_LIMIT_DEF) begin
              good_q = 1'b0;
              encoder_drops++;
            end
          end else begin
            stall_q = '0;
          end
          acc = clip32(acc + pid);
        end else begin
          if (closed_q && !good_q) acc = 0;
          if (good_q) begin
            g = m;
            r = m;
          end
          if (!good_q && m != 0) begin
            stall_q = '0;
            good_q = 1'b1;
            encoder_recoveries++;
          end
        end
        err2_q = err1_q;
        err1_q = 18'(r - m);
      end
      OP_TARGET: begin
        g = t;
        closed_q = 1'b1;
      end
      OP_OPEN: begin
        acc = clip32(p * PWM_SCALE);
        closed_q = 1'b0;
      end
      OP_LOCK: begin
        r = 0;
        g = 0;
        closed_q = 1'b1;
      end
      default: ;
    endcase
    ramp_q = 17'(r);
    goal_q = 17'(g);
    rem_q = 12'(rem);
    acc_q = 32'(acc);
    rep.pwm = int'(acc / PWM_SCALE);
    rep.cmd = int'($signed(ramp_q[15:0]));
    rep.tgt = int'($signed(goal_q[15:0]));
    rep.ok = good_q;
    rep.closed = closed_q;
    drive_reports_due.push_back(rep);
  endtask

  // register write over the apb port, then mirror it into the model
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACCEL: begin
        if (val[9:0] < ACCEL_MIN) accel_q = ACCEL_MIN;
        else if (val[9:0] > ACCEL_MAX) accel_q = ACCEL_MAX;
        else accel_q = val[9:0];
      end
      REG_GAIN_P: kp_q = val[15:0];
      REG_GAIN_I: ki_q = val[15:0];
      REG_GAIN_D: kd_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] a, input int p, input int i, input int d);
    write_reg(REG_ACCEL, ($urandom & 32'hFFFF_FC00) | (a & 32'h3FF));
    write_reg(REG_GAIN_P, {16'($urandom), 16'(p)});
    write_reg(REG_GAIN_I, {16'($urandom), 16'(i)});
    write_reg(REG_GAIN_D, {16'($urandom), 16'(d)});
    settings_applied++;
  endtask

  function automatic int small_gain();
    return $urandom_range(0, 600) - 300;
  endfunction

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'($urandom_range(0, 80) - 40);
      3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  task automatic push_op(input logic [2:0] op, input logic [15:0] m, input logic [15:0] t,
                         input logic [18:0] p);
    item_t it;
    it.opcode = op;
    it.meas = m;
    it.tgt = t;
    it.pwm = p;
    pending_items.push_back(it);
    phase_items++;
  endtask

  task automatic push_rand(input logic [2:0] op);
    push_op(op, 16'($urandom), 16'($urandom), 19'($urandom));
  endtask

  task automatic seq_ramp();
    int k;
    push_op(OP_TARGET, 16'($urandom), rand_vel(), 19'($urandom));
    k = $urandom_range(1, 40);
    repeat (k) begin
      if ($urandom_range(0, 7) == 0) push_op(OP_CONTROL, rand_vel(), 16'($urandom), 19'($urandom));
      else push_rand(OP_RAMP);
    end
  endtask

  task automatic seq_pid();
    int k;
    push_op(OP_TARGET, 16'($urandom), rand_vel(), 19'($urandom));
    k = $urandom_range(2, 20);
    repeat (k) begin
      if ($urandom_range(0, 5) == 0) push_rand(OP_RAMP);
      else push_op(OP_CONTROL, rand_vel(), 16'($urandom), 19'($urandom));
    end
  endtask

  // hold a nonzero command against a dead encoder near the stall limit, so it trips or not, then show motion
  task automatic seq_stall();
    logic [15:0] v;
    int n, brk;
    v = 16'($urandom_range(1, 32767));
    if ($urandom_range(0, 1)) v = -v;
    n = $urandom_range(95, 110);
    brk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
    push_rand(OP_OPEN);
    push_op(OP_CONTROL, v, 16'($urandom), 19'($urandom));
    push_op(OP_CONTROL, v, 16'($urandom), 19'($urandom));
    push_op(OP_TARGET, 16'($urandom), rand_vel(), 19'($urandom));
    for (int j = 0; j < n; j++) begin
      if (j == brk) push_op(OP_CONTROL, rand_vel() | 16'd1, 16'($urandom), 19'($urandom));
      else push_op(OP_CONTROL, 16'd0, 16'($urandom), 19'($urandom));
    end
    push_op(OP_CONTROL, 16'd0, 16'($urandom), 19'($urandom));
    push_op(OP_CONTROL, 16'd0, 16'($urandom), 19'($urandom));
    push_op(OP_CONTROL, rand_vel() | 16'd1, 16'($urandom), 19'($urandom));
  endtask

  task automatic seq_noise();
    int k;
    k = $urandom_range(1, 8);
    repeat (k) push_rand(3'($urandom_range(0, 7)));
  endtask

  task automatic build_phase(input int n);
    int pick;
    phase_items = 0;
    while (phase_items < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) seq_ramp();
      else if (pick < 58) seq_pid();
      else if (pick < 66) seq_stall();
      else seq_noise();
    end
  endtask

  task automatic load_directed();
    push_rand(OP_RAMP);
    push_rand(OP_SPARE5);
    push_rand(OP_SPARE6);
    push_rand(OP_SPARE7);
    push_op(OP_CONTROL, 16'h0000, 16'($urandom), 19'($urandom));
    push_op(OP_CONTROL, 16'h7FFF, 16'($urandom), 19'($urandom));
    push_op(OP_CONTROL, 16'h8000, 16'($urandom), 19'($urandom));
    push_op(OP_TARGET, 16'($urandom), 16'h7FFF, 19'($urandom));
    push_rand(OP_RAMP);
    push_rand(OP_RAMP);
    push_rand(OP_RAMP);
    push_op(OP_CONTROL, 16'h8000, 16'($urandom), 19'($urandom));
    push_op(OP_OPEN, 16'($urandom), 16'($urandom), 19'h3FFFF);
    push_op(OP_OPEN, 16'($urandom), 16'($urandom), 19'h40000);
    push_op(OP_OPEN, 16'($urandom), 16'($urandom), 19'(214748));
    push_op(OP_OPEN, 16'($urandom), 16'($urandom), 19'(-214748));
    push_op(OP_OPEN, 16'($urandom), 16'($urandom), 19'd0);
    push_rand(OP_LOCK);
    push_op(OP_TARGET, 16'($urandom), 16'h8000, 19'($urandom));
    push_rand(OP_RAMP);
    push_rand(OP_RAMP);
    push_op(OP_TARGET, 16'($urandom), 16'h0000, 19'($urandom));
    push_rand(OP_RAMP);
    push_op(OP_CONTROL, 16'h0000, 16'($urandom), 19'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || item_valid || drive_reports_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // transaction driver
  always @(posedge clk) begin : item_driver
    item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        advance_drive_model(opcode, measured_velocity, target_velocity, open_loop_pwm);
        items_taken++;
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0 && send_odds != 0 &&
                     $urandom_range(1, send_odds) == 1) begin
          send_gap <= $urandom_range(0, 18);
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          opcode <= nxt.opcode;
          measured_velocity <= nxt.meas;
          target_velocity <= nxt.tgt;
          open_loop_pwm <= nxt.pwm;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  // result monitor and receiver-side stall
  always @(posedge clk) begin : result_monitor
    drive_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (drive_reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: result expected none actual pwm %0d cmd %0d", $time,
                     $signed(pwm_drive), $signed(commanded_velocity));
        end else begin
          want = drive_reports_due.pop_front();
          check_field("pwm_drive", want.pwm, int'($signed(pwm_drive)));
          check_field("commanded_velocity", want.cmd, int'($signed(commanded_velocity)));
          check_field("target_now", want.tgt, int'($signed(target_now)));
          check_field("encoder_ok", want.ok, int'(encoder_ok));
          check_field("loop_closed", want.closed, int'(loop_closed));
          results_checked++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_stall <= 1'b1;
      end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
        recv_gap <= $urandom_range(0, 18);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    load_directed();
    wait_drained();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_setting(32'd0, 32767, -32768, 32767);
        1: apply_setting(32'd1023, -32768, 32767, -32768);
        2: apply_setting(32'd1, small_gain(), small_gain(), small_gain());
        3: apply_setting(32'd1001, int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768);
        4: apply_setting($urandom_range(2, 1000), small_gain(), small_gain(), small_gain());
        default: apply_setting($urandom_range(0, 1023), small_gain(), small_gain(),
                               small_gain());
      endcase
      if (ph == NUM_PHASES - 1) begin
        send_odds = 0;
        recv_odds = 0;
      end else begin
        send_odds = (ph % 2 == 0) ? 4 : 30;
        recv_odds = (ph % 2 == 0) ? 30 : 4;
      end
      @(negedge clk);
      build_phase(PHASE_ITEMS);
      wait_drained();
    end
    repeat (10) @(posedge clk);
    $display("covered %0d transactions over %0d register settings, %0d results checked",
             items_taken, settings_applied, results_checked);
    $display("encoder dropped %0d times and recovered %0d times", encoder_drops,
             encoder_recoveries);
    if (mismatches == 0 && drive_reports_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
